// ===== rtl/core/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Types, operation and status codes shared by the LIFO stack modules.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned LSS_STACK_DEPTH = 16;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 5;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;
  localparam logic [1:0] KIND_SEARCH = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Value returned by a pop on an empty stack.
  localparam logic signed [WORD_W-1:0] POP_UNDER_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [1:0]               status;
    logic [POS_W-1:0]         position;
    logic                     empty_now;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input item into the operation registers
    logic exec;      // carry out the first step of the operation
    logic rd_done;   // read data of a pop or peek is ready
    logic srch;      // one compare step of a search
    logic load_out;  // move the finished result into the output register
  } lss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       hit;
    logic       last;
  } lss_sts_t;

endpackage

// ===== rtl/core/lifo_stack_with_search_top.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top: bounded LIFO stack of signed words with search.
// Each item is accepted in idle and worked through to its result before the next
// is taken; a search compares one entry per cycle from the top down, at most
// STACK_DEPTH entries. Reset clears the entry count and output valid at once;
// the memory is not cleared, unread until written.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top
  import lss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = LSS_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // The controller steps each item through capture, execution, an optional
  // memory read or search walk, and a final hand-over into the output
  // register. A new item is accepted as soon as the controller is back in
  // its idle state, even while the previous result still waits downstream.
  lss_cmd_t cmd;
  lss_sts_t sts;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the stack memory, the entry count, the search
  // pointer and position counter, and both the result and output registers.
  lss_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  // The controller issues at most one command in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.exec, cmd.rd_done, cmd.srch, cmd.load_out}))
    else $error("more than one datapath command in one cycle");

  // An accepted item is always executed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.exec)
    else $error("accepted item was not executed");

  // A result is only loaded when the output register is free or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten while held");

  // An overflow can only happen on a full, hence non-empty, stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_OVER) |-> !out_item_o.empty_now)
    else $error("overflow reported on an empty stack");

endmodule

// ===== rtl/core/lss_dp.sv =====
// ----------------------------------------------------------------------------
// lss_dp
// Stack datapath: entry memory, entry count, search pointer and result
// registers.
// ----------------------------------------------------------------------------
module lss_dp
  import lss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = LSS_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lss_cmd_t  cmd_i,
  output lss_sts_t  sts_o,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_q;

  logic [CNTW-1:0]          count_q, count_d;
  logic [1:0]               kind_q;
  logic signed [WORD_W-1:0] operand_q;
  logic [AW-1:0]            addr_q, addr_d;
  logic [CNTW-1:0]          pos_q, pos_d;
  out_item_t                res_q, res_d;
  out_item_t                out_q;

  logic            mem_we, mem_re;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   top_addr;
  logic            cnt_zero, cnt_full;
  logic [CNTW+POS_W-1:0] pos_wide;

  assign cnt_zero = (count_q == '0);
  assign cnt_full = (count_q == CNTW'(STACK_DEPTH));
  assign top_addr = AW'(count_q - 1'b1);
  assign pos_wide = {{POS_W{1'b0}}, pos_q};

  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    raddr   = top_addr;
    count_d = count_q;
    addr_d  = addr_q;
    pos_d   = pos_q;
    res_d   = res_q;

    if (cmd_i.exec) begin
      res_d.result_value = '0;
      res_d.status       = ST_OK;
      res_d.position     = '0;
      res_d.empty_now    = cnt_zero;
      case (kind_q)
        KIND_PUSH: begin
          if (cnt_full) begin
            res_d.status = ST_OVER;
          end else begin
            mem_we          = 1'b1;
            count_d         = count_q + 1'b1;
            res_d.empty_now = 1'b0;
          end
        end
        KIND_POP: begin
          if (cnt_zero) begin
            res_d.result_value = POP_UNDER_VALUE;
            res_d.status       = ST_UNDER;
          end else begin
            mem_re  = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        KIND_PEEK: begin
          if (cnt_zero) begin
            res_d.status = ST_UNDER;
          end else begin
            mem_re = 1'b1;
          end
        end
        default: begin
          if (cnt_zero) begin
            res_d.status = ST_UNDER;
          end else begin
            mem_re = 1'b1;
            addr_d = top_addr;
            pos_d  = CNTW'(1);
          end
        end
      endcase
    end else if (cmd_i.rd_done) begin
      res_d.result_value = rd_q;
      res_d.status       = ST_OK;
      res_d.position     = '0;
      res_d.empty_now    = cnt_zero;
    end else if (cmd_i.srch) begin
      res_d.result_value = '0;
      res_d.position     = '0;
      res_d.empty_now    = cnt_zero;
      if (rd_q == operand_q) begin
        res_d.status   = ST_OK;
        res_d.position = pos_wide[POS_W-1:0];
      end else if (pos_q == count_q) begin
        res_d.status = ST_MISS;
      end else begin
        mem_re = 1'b1;
        raddr  = AW'(addr_q - 1'b1);
        addr_d = AW'(addr_q - 1'b1);
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= operand_q;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= in_item_i.kind;
      operand_q <= in_item_i.operand;
    end
    addr_q <= addr_d;
    pos_q  <= pos_d;
    res_q  <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.cnt_zero = cnt_zero;
  assign sts_o.hit      = (rd_q == operand_q);
  assign sts_o.last     = (pos_q == count_q);
  assign out_item_o     = out_q;

endmodule

// ===== rtl/core/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl
// Stack controller: sequences each operation and owns the output valid flag.
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lss_cmd_t cmd_o,
  input  lss_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SRCH,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.kind == KIND_PUSH || sts_i.cnt_zero) begin
          state_d = S_DONE;
        end else if (sts_i.kind == KIND_SEARCH) begin
          state_d = S_SRCH;
        end else begin
          state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_done = 1'b1;
        state_d       = S_DONE;
      end
      S_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
